// File: sv/pei_pkg.sv
// ----------------------------------------------------------------------------
// pei_pkg
// Shared constants, types and helper functions of the pendulum integrator.
// ----------------------------------------------------------------------------
package pei_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int MAX_PASSES = 100;
   localparam int STEP_FRAC  = 24;
   localparam int GOL_FRAC   = 16;
   localparam int SINE_FRAC  = 30;

   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int PASS_W = $clog2(MAX_PASSES + 2);

   // range reduction: offset by 2^RED_K turns, then restoring steps RED_K..0
   localparam int RED_K  = 29 - FRAC_BITS;
   localparam int RED_CW = $clog2(RED_K + 1);

   localparam int SERIES_N = 6;
   localparam int SER_IW   = 3;

   localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
   localparam logic [63:0] PI_Q30      = (PI_Q60 + (64'd1 << 29)) >> 30;
   localparam logic [63:0] TWO_PI_Q30  = (PI_Q60 + (64'd1 << 28)) >> 29;
   localparam logic [63:0] HALF_PI_Q30 = (PI_Q60 + (64'd1 << 30)) >> 31;
   localparam logic [63:0] ONE_Q30     = 64'd1 << SINE_FRAC;
   localparam logic [63:0] HALF_PI_QF  =
      (PI_Q60 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
   localparam logic [63:0] TOL_Q2F     =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000;
   localparam logic [63:0] CHANGE_LIM  = 64'd1 << FRAC_BITS;

   localparam logic [31:0] ANGLE_RESET = HALF_PI_QF[31:0];

   localparam logic [23:0]        STEP_RESET = 24'd335544;
   localparam logic signed [24:0] GOL_RESET  = -25'sd642908;

   localparam logic [1:0] CSR_STEP_SIZE = 2'd0;
   localparam logic [1:0] CSR_GRAVITY   = 2'd1;
   localparam logic [1:0] CSR_MODE      = 2'd2;

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef enum logic [1:0] {
      MODE_FORWARD,
      MODE_SEMI,
      MODE_BACKWARD,
      MODE_UNUSED
   } mode_type;

   typedef struct packed {
      logic [23:0]        step_size;
      logic signed [24:0] gravity;
      mode_type           mode;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic [6:0]         passes;
      logic               hit;
   } result_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RED_LD,
      ST_RED,
      ST_FOLD1,
      ST_FOLD2,
      ST_X2_MUL,
      ST_X2_RND,
      ST_T_MUL,
      ST_T_RND,
      ST_D_MUL,
      ST_D_RND,
      ST_D_FIX,
      ST_S_MUL,
      ST_S_RND,
      ST_G_MUL,
      ST_G_RND,
      ST_RT_MUL,
      ST_RT_RND,
      ST_AT_MUL,
      ST_AT_RND,
      ST_E_MUL,
      ST_F_MUL,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Horner divisors of the sine series, innermost first
   function automatic logic [7:0] series_div(input logic [SER_IW-1:0] i);
      case (i)
         3'd0:    return 8'd156;
         3'd1:    return 8'd110;
         3'd2:    return 8'd72;
         3'd3:    return 8'd42;
         3'd4:    return 8'd20;
         3'd5:    return 8'd6;
         default: return 8'd6;
      endcase
   endfunction

   // floor(2^32 / divisor)
   function automatic logic [MUL_W-1:0] series_recip(input logic [SER_IW-1:0] i);
      case (i)
         3'd0:    return 34'd27531841;
         3'd1:    return 34'd39045157;
         3'd2:    return 34'd59652323;
         3'd3:    return 34'd102261126;
         3'd4:    return 34'd214748364;
         3'd5:    return 34'd715827882;
         default: return 34'd715827882;
      endcase
   endfunction

   // arithmetic right shift, round half away from zero
   function automatic logic signed [PROD_W-1:0] rshr(
      input logic signed [PROD_W-1:0] v,
      input int                       s
   );
      logic signed [PROD_W-1:0] half;
      logic signed [PROD_W-1:0] neg;
      half = PROD_W'(1) <<< (s - 1);
      neg  = $signed({{(PROD_W-1){1'b0}}, v[PROD_W-1]});
      return (v + half - neg) >>> s;
   endfunction

   // {saturated, value}
   function automatic logic [32:0] sat32(input logic signed [39:0] v);
      if (v > 40'sh007FFFFFFF) begin
         return {1'b1, 32'h7FFFFFFF};
      end else if (v < -40'sh0080000000) begin
         return {1'b1, 32'h80000000};
      end
      return {1'b0, v[31:0]};
   endfunction

endpackage

// File: sv/pei_mul.sv
// ----------------------------------------------------------------------------
// pei_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pei_mul (
   input  logic                                 clock,
   input  logic signed [pei_pkg::MUL_W-1:0]     mul_a,
   input  logic signed [pei_pkg::MUL_W-1:0]     mul_b,
   output logic signed [pei_pkg::PROD_W-1:0]    prod
);

   logic signed [pei_pkg::PROD_W-1:0] prod_ff;
   logic signed [pei_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mul_a * mul_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// File: sv/pei_core.sv
// ----------------------------------------------------------------------------
// pei_core
// Sequencer and datapath: sine, acceleration, Euler updates and the
// implicit iteration, all on one shared multiplier.
// ----------------------------------------------------------------------------
module pei_core (
   input  logic                  clock,
   input  logic                  reset,
   input  pei_pkg::cfg_type      cfg,
   input  logic                  start,
   input  logic                  cmd,
   input  logic signed [31:0]    load_angle,
   input  logic signed [31:0]    load_rate,
   input  logic                  taken,
   output logic                  idle,
   output logic                  done,
   output pei_pkg::result_type   result
);

   localparam logic signed [35:0] PI_S   = 36'(pei_pkg::PI_Q30);
   localparam logic signed [35:0] HALF_S = 36'(pei_pkg::HALF_PI_Q30);
   localparam logic signed [32:0] LIM_S  = 33'(pei_pkg::CHANGE_LIM);

   pei_pkg::state_type state_ff, state_in;

   logic [63:0]                        u_ff, u_in;
   logic [pei_pkg::RED_CW-1:0]         k_ff, k_in;
   logic signed [35:0]                 r_ff, r_in;
   logic signed [32:0]                 x2_ff, x2_in;
   logic signed [31:0]                 t_ff, t_in;
   logic signed [32:0]                 n_ff, n_in;
   logic signed [32:0]                 q_ff, q_in;
   logic [pei_pkg::SER_IW-1:0]         i_ff, i_in;
   logic signed [31:0]                 sine_ff, sine_in;
   logic signed [33:0]                 alpha_ff, alpha_in;
   logic signed [31:0]                 an_ff, an_in;
   logic signed [31:0]                 rn_ff, rn_in;
   logic signed [31:0]                 at_ff, at_in;
   logic signed [31:0]                 rt_ff, rt_in;
   logic signed [31:0]                 ang_ff, ang_in;
   logic signed [31:0]                 rat_ff, rat_in;
   logic [pei_pkg::PROD_W-1:0]         ee_ff, ee_in;
   logic                               sat_ff, sat_in;
   logic [pei_pkg::PASS_W-1:0]         passes_ff, passes_in;
   logic                               hit_ff, hit_in;

   logic signed [pei_pkg::MUL_W-1:0]   mul_a, mul_b;
   logic signed [pei_pkg::PROD_W-1:0]  prod;

   logic signed [32:0]                 e_w, f_w;
   logic [pei_pkg::PROD_W-1:0]         sq_sum;
   logic                               ok, finish, quick;
   logic [63:0]                        red_sub;
   logic [7:0]                         div_k;
   logic [41:0]                        rem_w;
   logic [32:0]                        q_fix;
   logic [32:0]                        rt_sat, at_sat;

   pei_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   assign e_w     = 33'(at_ff) - 33'(an_ff);
   assign f_w     = 33'(rt_ff) - 33'(rn_ff);
   assign sq_sum  = ee_ff + prod;
   assign ok      = (e_w < LIM_S) && (e_w > -LIM_S) && (f_w < LIM_S) && (f_w > -LIM_S)
                    && (sq_sum < pei_pkg::PROD_W'(pei_pkg::TOL_Q2F));
   assign finish  = ok || (passes_ff > pei_pkg::PASS_W'(pei_pkg::MAX_PASSES));
   assign quick   = (cmd == pei_pkg::CMD_LOAD) || (cfg.mode == pei_pkg::MODE_UNUSED);
   assign red_sub = pei_pkg::TWO_PI_Q30 << k_ff;
   assign div_k   = pei_pkg::series_div(i_ff);
   assign rem_w   = {9'b0, n_ff} - {9'b0, q_ff} * {34'b0, div_k};
   assign q_fix   = (rem_w >= {34'b0, div_k}) ? 33'(q_ff) + 33'd1 : 33'(q_ff);
   assign rt_sat  = pei_pkg::sat32(40'(rat_ff)
                    + 40'(pei_pkg::rshr(prod, pei_pkg::STEP_FRAC)));
   assign at_sat  = pei_pkg::sat32(40'(ang_ff)
                    + 40'(pei_pkg::rshr(prod, pei_pkg::STEP_FRAC)));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pei_pkg::ST_IDLE: begin
            if (start) begin
               state_in = quick ? pei_pkg::ST_DONE : pei_pkg::ST_RED_LD;
            end
         end
         pei_pkg::ST_RED_LD: state_in = pei_pkg::ST_RED;
         pei_pkg::ST_RED: begin
            if (k_ff == '0) begin
               state_in = pei_pkg::ST_FOLD1;
            end
         end
         pei_pkg::ST_FOLD1:  state_in = pei_pkg::ST_FOLD2;
         pei_pkg::ST_FOLD2:  state_in = pei_pkg::ST_X2_MUL;
         pei_pkg::ST_X2_MUL: state_in = pei_pkg::ST_X2_RND;
         pei_pkg::ST_X2_RND: state_in = pei_pkg::ST_T_MUL;
         pei_pkg::ST_T_MUL:  state_in = pei_pkg::ST_T_RND;
         pei_pkg::ST_T_RND:  state_in = pei_pkg::ST_D_MUL;
         pei_pkg::ST_D_MUL:  state_in = pei_pkg::ST_D_RND;
         pei_pkg::ST_D_RND:  state_in = pei_pkg::ST_D_FIX;
         pei_pkg::ST_D_FIX: begin
            if (i_ff == pei_pkg::SER_IW'(pei_pkg::SERIES_N - 1)) begin
               state_in = pei_pkg::ST_S_MUL;
            end else begin
               state_in = pei_pkg::ST_T_MUL;
            end
         end
         pei_pkg::ST_S_MUL:  state_in = pei_pkg::ST_S_RND;
         pei_pkg::ST_S_RND:  state_in = pei_pkg::ST_G_MUL;
         pei_pkg::ST_G_MUL:  state_in = pei_pkg::ST_G_RND;
         pei_pkg::ST_G_RND:  state_in = pei_pkg::ST_RT_MUL;
         pei_pkg::ST_RT_MUL: state_in = pei_pkg::ST_RT_RND;
         pei_pkg::ST_RT_RND: state_in = pei_pkg::ST_AT_MUL;
         pei_pkg::ST_AT_MUL: state_in = pei_pkg::ST_AT_RND;
         pei_pkg::ST_AT_RND: begin
            if (cfg.mode == pei_pkg::MODE_BACKWARD) begin
               state_in = pei_pkg::ST_E_MUL;
            end else begin
               state_in = pei_pkg::ST_DONE;
            end
         end
         pei_pkg::ST_E_MUL:  state_in = pei_pkg::ST_F_MUL;
         pei_pkg::ST_F_MUL:  state_in = pei_pkg::ST_CHECK;
         pei_pkg::ST_CHECK: begin
            state_in = finish ? pei_pkg::ST_DONE : pei_pkg::ST_RED_LD;
         end
         pei_pkg::ST_DONE: begin
            if (taken) begin
               state_in = pei_pkg::ST_IDLE;
            end
         end
         default: state_in = pei_pkg::ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      u_in      = u_ff;
      k_in      = k_ff;
      r_in      = r_ff;
      x2_in     = x2_ff;
      t_in      = t_ff;
      n_in      = n_ff;
      q_in      = q_ff;
      i_in      = i_ff;
      sine_in   = sine_ff;
      alpha_in  = alpha_ff;
      an_in     = an_ff;
      rn_in     = rn_ff;
      at_in     = at_ff;
      rt_in     = rt_ff;
      ang_in    = ang_ff;
      rat_in    = rat_ff;
      ee_in     = ee_ff;
      sat_in    = sat_ff;
      passes_in = passes_ff;
      hit_in    = hit_ff;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         pei_pkg::ST_IDLE: begin
            if (start) begin
               passes_in = '0;
               hit_in    = 1'b0;
               sat_in    = 1'b0;
               an_in     = ang_ff;
               rn_in     = rat_ff;
               if (cmd == pei_pkg::CMD_LOAD) begin
                  ang_in = load_angle;
                  rat_in = load_rate;
               end
            end
         end
         pei_pkg::ST_RED_LD: begin
            u_in = (64'(an_ff) << (pei_pkg::SINE_FRAC - pei_pkg::FRAC_BITS))
                   + (pei_pkg::TWO_PI_Q30 << pei_pkg::RED_K);
            k_in = pei_pkg::RED_CW'(pei_pkg::RED_K);
         end
         pei_pkg::ST_RED: begin
            if (u_ff >= red_sub) begin
               u_in = u_ff - red_sub;
            end
            k_in = k_ff - pei_pkg::RED_CW'(1);
         end
         pei_pkg::ST_FOLD1: begin
            if (u_ff >= pei_pkg::PI_Q30) begin
               r_in = 36'(u_ff - pei_pkg::TWO_PI_Q30);
            end else begin
               r_in = 36'(u_ff);
            end
         end
         pei_pkg::ST_FOLD2: begin
            if (r_ff > HALF_S) begin
               r_in = PI_S - r_ff;
            end else if (r_ff < -HALF_S) begin
               r_in = -PI_S - r_ff;
            end
         end
         pei_pkg::ST_X2_MUL: begin
            mul_a = 34'(r_ff);
            mul_b = 34'(r_ff);
         end
         pei_pkg::ST_X2_RND: begin
            x2_in = 33'(pei_pkg::rshr(prod, pei_pkg::SINE_FRAC));
            t_in  = 32'(pei_pkg::ONE_Q30);
            i_in  = '0;
         end
         pei_pkg::ST_T_MUL: begin
            mul_a = 34'(x2_ff);
            mul_b = 34'(t_ff);
         end
         pei_pkg::ST_T_RND: begin
            n_in = 33'(pei_pkg::rshr(prod, pei_pkg::SINE_FRAC)) + 33'(div_k >> 1);
         end
         pei_pkg::ST_D_MUL: begin
            mul_a = 34'(n_ff);
            mul_b = pei_pkg::series_recip(i_ff);
         end
         pei_pkg::ST_D_RND: begin
            q_in = 33'(prod >>> 32);
         end
         pei_pkg::ST_D_FIX: begin
            t_in = 32'(33'(pei_pkg::ONE_Q30) - q_fix);
            i_in = i_ff + pei_pkg::SER_IW'(1);
         end
         pei_pkg::ST_S_MUL: begin
            mul_a = 34'(r_ff);
            mul_b = 34'(t_ff);
         end
         pei_pkg::ST_S_RND: begin
            sine_in = 32'(pei_pkg::rshr(prod, pei_pkg::SINE_FRAC));
         end
         pei_pkg::ST_G_MUL: begin
            mul_a = 34'(cfg.gravity);
            mul_b = 34'(sine_ff);
         end
         pei_pkg::ST_G_RND: begin
            alpha_in = 34'(pei_pkg::rshr(prod,
                       pei_pkg::SINE_FRAC + pei_pkg::GOL_FRAC - pei_pkg::FRAC_BITS));
         end
         pei_pkg::ST_RT_MUL: begin
            mul_a = 34'({1'b0, cfg.step_size});
            mul_b = alpha_ff;
         end
         pei_pkg::ST_RT_RND: begin
            rt_in  = rt_sat[31:0];
            sat_in = sat_ff | rt_sat[32];
         end
         pei_pkg::ST_AT_MUL: begin
            mul_a = 34'({1'b0, cfg.step_size});
            mul_b = (cfg.mode == pei_pkg::MODE_SEMI) ? 34'(rt_ff) : 34'(rn_ff);
         end
         pei_pkg::ST_AT_RND: begin
            if (cfg.mode == pei_pkg::MODE_BACKWARD) begin
               at_in     = at_sat[31:0];
               sat_in    = sat_ff | at_sat[32];
               passes_in = passes_ff + pei_pkg::PASS_W'(1);
            end else begin
               ang_in = at_sat[31:0];
               rat_in = rt_ff;
               hit_in = sat_ff | at_sat[32];
            end
         end
         pei_pkg::ST_E_MUL: begin
            mul_a = 34'(e_w);
            mul_b = 34'(e_w);
         end
         pei_pkg::ST_F_MUL: begin
            mul_a = 34'(f_w);
            mul_b = 34'(f_w);
            ee_in = prod;
         end
         pei_pkg::ST_CHECK: begin
            if (finish) begin
               ang_in = at_ff;
               rat_in = rt_ff;
               hit_in = sat_ff | ~ok;
            end else begin
               an_in  = at_ff;
               rn_in  = rt_ff;
               sat_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pei_pkg::ST_IDLE;
         ang_ff    <= pei_pkg::ANGLE_RESET;
         rat_ff    <= '0;
         passes_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         ang_ff    <= ang_in;
         rat_ff    <= rat_in;
         passes_ff <= passes_in;
         hit_ff    <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      u_ff     <= u_in;
      k_ff     <= k_in;
      r_ff     <= r_in;
      x2_ff    <= x2_in;
      t_ff     <= t_in;
      n_ff     <= n_in;
      q_ff     <= q_in;
      i_ff     <= i_in;
      sine_ff  <= sine_in;
      alpha_ff <= alpha_in;
      an_ff    <= an_in;
      rn_ff    <= rn_in;
      at_ff    <= at_in;
      rt_ff    <= rt_in;
      ee_ff    <= ee_in;
      sat_ff   <= sat_in;
   end

   assign idle          = (state_ff == pei_pkg::ST_IDLE);
   assign done          = (state_ff == pei_pkg::ST_DONE);
   assign result.angle  = ang_ff;
   assign result.rate   = rat_ff;
   assign result.passes = 7'(passes_ff);
   assign result.hit    = hit_ff;

endmodule

// File: sv/pendulum_euler_integrator.sv
// ----------------------------------------------------------------------------
// pendulum_euler_integrator
// Fixed-point pendulum stepper with explicit, semi-implicit and implicit
// Euler updates, a configuration port and a registered result stream.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load, or a tick in the unused mode, goes
// straight to the done state. An implicit tick runs up to 101 passes. The
// sequencer steps range reduction, the six Horner steps of the sine and the
// Euler updates through one shared 34x34 multiplier with a registered
// product. A finished result waits in the output register while the next
// item is accepted.
module pendulum_euler_integrator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // load_angle[31:0], load_rate[63:32]
   input  logic        req_tuser,   // cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // angle_out, rate_out, passes_used, hit_limit
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [24:0] csr_data
);

   pei_pkg::cfg_type    cfg_ff, cfg_in;
   pei_pkg::result_type result;
   pei_pkg::result_type rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                core_idle, core_done, take;

   pei_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .start      (req_tvalid & req_tready),
      .cmd        (req_tuser),
      .load_angle (req_tdata[31:0]),
      .load_rate  (req_tdata[63:32]),
      .taken      (take),
      .idle       (core_idle),
      .done       (core_done),
      .result     (result)
   );

   assign req_tready = core_idle;
   assign csr_ready  = 1'b1;
   assign take       = core_done & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid & csr_ready) begin
         case (csr_index)
            pei_pkg::CSR_STEP_SIZE: cfg_in.step_size = csr_data[23:0];
            pei_pkg::CSR_GRAVITY:   cfg_in.gravity   = csr_data;
            pei_pkg::CSR_MODE:      cfg_in.mode      = pei_pkg::mode_type'(csr_data[1:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_in       = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size <= pei_pkg::STEP_RESET;
         cfg_ff.gravity   <= pei_pkg::GOL_RESET;
         cfg_ff.mode      <= pei_pkg::MODE_FORWARD;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.hit, rsp_ff.passes, rsp_ff.rate, rsp_ff.angle};

endmodule

// File: tb/pendulum_euler_integrator_tb.sv
// ----------------------------------------------------------------------------
// pendulum_euler_integrator_tb
// Self-checking bench: a software twin of the integrator predicts each
// result, a small scoreboard compares results field by field, and plain
// tasks drive ticks, loads and register writes under random idling.
// ----------------------------------------------------------------------------
module pendulum_euler_integrator_tb;

   localparam logic [1:0] CSR_SPARE = 2'd3;

   typedef struct {
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic [6:0]         passes;
      logic               hit;
   } pend_result_type;

   class pend_scoreboard_type;
      pend_result_type pending[$];
      int errors;
      int checked;
      logic signed [31:0] angle;
      logic signed [31:0] rate;
      logic [23:0]        h;
      logic signed [24:0] gol;
      logic [1:0]         mode;

      function void clear_state();
         angle = 32'sd26353589;
         rate  = 0;
         h     = 24'd335544;
         gol   = -25'sd642908;
         mode  = pei_pkg::MODE_FORWARD;
      endfunction

      function void write_reg(logic [1:0] idx, logic [24:0] v);
         if (idx == pei_pkg::CSR_STEP_SIZE) begin
            h = v[23:0];
         end else if (idx == pei_pkg::CSR_GRAVITY) begin
            gol = $signed(v);
         end else if (idx == pei_pkg::CSR_MODE) begin
            mode = v[1:0];
         end
      endfunction

      function longint round_shift(longint v, int s);
         longint u;
         u = (v < 0) ? -v : v;
         u = (u + (longint'(1) << (s - 1))) >>> s;
         return (v < 0) ? -u : u;
      endfunction

      function logic signed [31:0] clamp32(longint v, ref bit flag);
         if (v > 64'sd2147483647) begin
            flag = 1;
            return 32'h7FFFFFFF;
         end
         if (v < -64'sd2147483648) begin
            flag = 1;
            return 32'h80000000;
         end
         return v[31:0];
      endfunction

      function longint sine30(logic signed [31:0] a);
         longint pi30, tpi30, hpi30, one, r, x2, t, k;
         longint divs[6];
         divs = '{156, 110, 72, 42, 20, 6};
         pi30  = longint'((pei_pkg::PI_Q60 + (64'd1 << 29)) >> 30);
         tpi30 = longint'((pei_pkg::PI_Q60 + (64'd1 << 28)) >> 29);
         hpi30 = longint'((pei_pkg::PI_Q60 + (64'd1 << 30)) >> 31);
         one   = longint'(1) << 30;
         r = longint'(a) * 64;
         r = r % tpi30;
         if (r < 0) r += tpi30;
         if (r >= pi30) r -= tpi30;
         if (r > hpi30) r = pi30 - r;
         else if (r < -hpi30) r = -pi30 - r;
         x2 = round_shift(r * r, 30);
         t = one;
         for (int i = 0; i < 6; i++) begin
            k = divs[i];
            t = one - (round_shift(x2 * t, 30) + k / 2) / k;
         end
         return round_shift(r * t, 30);
      endfunction

      function longint accel(logic signed [31:0] a);
         return round_shift(longint'(gol) * sine30(a), 22);
      endfunction

      function logic signed [31:0] euler(logic signed [31:0] b, longint v, ref bit flag);
         return clamp32(longint'(b) + round_shift(longint'({40'd0, h}) * v, 24), flag);
      endfunction

      function bit converged(logic signed [31:0] a, b, c, d);
         longint e, f, lim;
         e = longint'(a) - longint'(b);
         f = longint'(c) - longint'(d);
         lim = longint'(1) << 24;
         if (e >= lim || e <= -lim || f >= lim || f <= -lim) return 0;
         return (e * e + f * f) < longint'(pei_pkg::TOL_Q2F);
      endfunction

      function void note_item(bit load, logic [31:0] la, logic [31:0] lr);
         pend_result_type x;
         bit lim, sat, ok;
         logic signed [31:0] na, an, rn, at, rt;
         longint al;
         int p;
         lim = 0;
         p = 0;
         if (load) begin
            angle = la;
            rate = lr;
         end else if (mode == pei_pkg::MODE_FORWARD) begin
            al = accel(angle);
            na = euler(angle, rate, lim);
            rate = euler(rate, al, lim);
            angle = na;
         end else if (mode == pei_pkg::MODE_SEMI) begin
            rate = euler(rate, accel(angle), lim);
            angle = euler(angle, rate, lim);
         end else if (mode == pei_pkg::MODE_BACKWARD) begin
            an = angle;
            rn = rate;
            forever begin
               sat = 0;
               at = euler(angle, rn, sat);
               rt = euler(rate, accel(an), sat);
               p++;
               ok = converged(at, an, rt, rn);
               if (ok || p > pei_pkg::MAX_PASSES) begin
                  angle = at;
                  rate = rt;
                  lim = sat || !ok;
                  break;
               end
               an = at;
               rn = rt;
            end
         end
         x.angle = angle;
         x.rate = rate;
         x.passes = p[6:0];
         x.hit = lim;
         pending.push_back(x);
      endfunction

      function void check_result(logic [71:0] d);
         pend_result_type x;
         checked++;
         if (pending.size() == 0) begin
            $error("unexpected result item %h", d);
            errors++;
            return;
         end
         x = pending.pop_front();
         if (d[31:0] !== x.angle) begin
            $error("angle_out expected %h actual %h", x.angle, d[31:0]);
            errors++;
         end
         if (d[63:32] !== x.rate) begin
            $error("rate_out expected %h actual %h", x.rate, d[63:32]);
            errors++;
         end
         if (d[70:64] !== x.passes) begin
            $error("passes_used expected %0d actual %0d", x.passes, d[70:64]);
            errors++;
         end
         if (d[71] !== x.hit) begin
            $error("hit_limit expected %0d actual %0d", x.hit, d[71]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = 0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = 0;
   logic [24:0] csr_data = 0;

   int  send_idle = 0;
   int  recv_stall = 0;
   bit  hold_off = 0;
   int  n_ticks = 0;
   int  n_loads = 0;
   pend_scoreboard_type board;

   pendulum_euler_integrator i_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("[pendulum_euler_integrator] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (reset || hold_off) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         board.check_result(rsp_tdata);
      end
   end

   task automatic send_item(bit load, logic [31:0] la, logic [31:0] lr);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= load;
      req_tdata <= {lr, la};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_item(load, la, lr);
      if (load) n_loads++;
      else n_ticks++;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      while (guard < 8) begin
         @(posedge clock);
         guard++;
      end
   endtask

   task automatic write_csr(logic [1:0] idx, logic [24:0] v);
      drain();
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, v);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic setup(logic [23:0] h, logic signed [24:0] g, logic [1:0] m);
      write_csr(pei_pkg::CSR_STEP_SIZE, 25'(h));
      write_csr(pei_pkg::CSR_GRAVITY, g);
      write_csr(pei_pkg::CSR_MODE, 25'(m));
   endtask

   task automatic random_item();
      logic [31:0] a, r;
      a = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(100_000_000)) - 50_000_000;
      r = $urandom_range(3) == 0 ? $urandom() : $signed($urandom_range(40_000_000)) - 20_000_000;
      send_item($urandom_range(3) == 0, a, r);
   endtask

   initial begin
      board = new();
      board.clear_state();
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: default registers, then extremes and every mode
      send_item(pei_pkg::CMD_TICK, 0, 0);
      send_item(pei_pkg::CMD_LOAD, 32'h7FFFFFFF, 32'h80000000);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      send_item(pei_pkg::CMD_LOAD, 32'h80000000, 32'h7FFFFFFF);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      setup(24'hFFFFFF, 25'sd15728640, pei_pkg::MODE_SEMI);
      send_item(pei_pkg::CMD_LOAD, 32'h7FFF0000, 32'h7FFF0000);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      setup(24'd1, -25'sd15728640, pei_pkg::MODE_BACKWARD);
      send_item(pei_pkg::CMD_LOAD, 32'd26353589, 0);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      setup(24'hFFFFFF, -25'sd15728640, pei_pkg::MODE_BACKWARD);
      send_item(pei_pkg::CMD_LOAD, 32'h01000000, 32'h02000000);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      send_item(pei_pkg::CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_item(pei_pkg::CMD_TICK, 0, 0);
      write_csr(pei_pkg::CSR_MODE, 25'(pei_pkg::MODE_UNUSED));
      send_item(pei_pkg::CMD_TICK, 0, 0);
      write_csr(CSR_SPARE, 25'h1FFFFFF);
      write_csr(pei_pkg::CSR_GRAVITY, 25'h1FFFFFF);
      write_csr(pei_pkg::CSR_MODE, 25'(pei_pkg::MODE_FORWARD));
      send_item(pei_pkg::CMD_TICK, 0, 0);
      send_item(pei_pkg::CMD_LOAD, 32'hAAAAAAAA, 32'h55555555);
      send_item(pei_pkg::CMD_TICK, 0, 0);

      for (int ph = 0; ph < 4; ph++) begin
         send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 81 : 38) : 0;
         recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 81 : 38) : 0;
         setup(24'($urandom_range(3) == 0 ? $urandom_range(24'hFFFFFF, 1)
                                          : $urandom_range(700_000, 1)),
               25'($signed($urandom_range(31_457_280)) - 15_728_640),
               2'($urandom_range(3)));
         for (int i = 0; i < 30; i++) random_item();
      end
      send_idle = 0;
      recv_stall = 0;
      setup(24'd335544, -25'sd642908, pei_pkg::MODE_FORWARD);
      fork
         begin
            hold_off = 1;
            repeat (300) @(posedge clock);
            hold_off = 0;
         end
         for (int i = 0; i < 6; i++) random_item();
      join
      drain();
      for (int i = 0; i < 6; i++) random_item();
      drain();

      $display("covered %0d ticks and %0d loads, %0d results checked, all modes and stalls",
               n_ticks, n_loads, board.checked);
      if (board.errors == 0) begin
         $display("[pendulum_euler_integrator] OK");
      end else begin
         $display("[pendulum_euler_integrator] ERROR");
      end
      $finish;
   end
endmodule
